>>> sv/battery_level_history_log_core_macros.svh
// Assertion macros shared by the battery level history log RTL.
`ifndef BATTERY_LEVEL_HISTORY_LOG_CORE_MACROS_SVH
`define BATTERY_LEVEL_HISTORY_LOG_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLH_ASSERT_SAME(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BLH_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> sv/blh_pkg.sv
package blh_pkg;

  // Default ring depth.
  localparam int DEPTH_DEFAULT = 128;

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int TIME_W  = 16;
  localparam int LEVEL_W = 7;
  localparam int RIDX_W  = 8;
  localparam int SLOT_W  = 7;
  localparam int COUNT_W = 8;
  localparam int ENTRY_W = TIME_W + LEVEL_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAVE_LEVEL_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAVE_INTERVAL_SEC       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAME_LEVEL_INTERVAL_SEC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ZERO_LEVEL       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ON_USB_POWER       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_SAVE_ON_SLEEP     = 3'd5;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] SAVE_LEVEL_THRESHOLD_RST    = 7'd5;
  localparam logic [TIME_W-1:0]  SAVE_INTERVAL_SEC_RST       = 16'd3600;
  localparam logic [TIME_W-1:0]  SAME_LEVEL_INTERVAL_SEC_RST = 16'd1200;

  // A full battery, the level assumed saved after reset.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_SLEEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Depth of the command queue between front and back.
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_READ,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] save_level_step;
    logic [TIME_W-1:0]  save_period_sec;
    logic [TIME_W-1:0]  same_level_interval_sec;
    logic               ignore_zero_level;
    logic               skip_on_usb_power;
    logic               force_save_on_sleep;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [TIME_W-1:0]  timestamp_sec;
    logic [LEVEL_W-1:0] level_percent;
    logic               level_valid;
    logic               usb_powered;
    logic [RIDX_W-1:0]  read_index;
  } cmd_t;

  // A classified request as it travels from front to back.
  typedef struct packed {
    kind_t              kind;
    logic               sleep;
    logic               take;
    logic               usb_powered;
    logic [TIME_W-1:0]  timestamp_sec;
    logic [LEVEL_W-1:0] level_percent;
    logic [RIDX_W-1:0]  read_index;
  } work_t;

  typedef struct packed {
    logic               recorded;
    logic               save_now;
    logic [SLOT_W-1:0]  save_first_slot;
    logic [COUNT_W-1:0] save_entry_count;
    logic [SLOT_W-1:0]  oldest_slot;
    logic [COUNT_W-1:0] entry_count;
    logic [TIME_W-1:0]  read_time;
    logic [LEVEL_W-1:0] read_level;
    logic               status;
    logic [LEVEL_W-1:0] level_latest;
  } result_t;

endpackage

>>> sv/battery_level_history_log_core.sv
// Battery level history log: a ring of (timestamp, level) entries.
// Requests enter through push/full with the cmd payload (sample, sleep sample,
// read by logical index, clear); a request is taken when push is high and
// full is low. Results leave through empty/pop with the result payload; the
// oldest result is shown while empty is low and leaves when pop is high.
// Registers are written through cfg_en/cfg_addr/cfg_data; the user must write
// them only while idle, and the block itself does not enforce this.
// The front classifies each request into a two-entry queue; the back takes
// one request at a time: in the take cycle it does the synchronous read of the
// entry memory (newest entry or the entry to read), and in the execute state it
// decides, writes the new entry and loads the result register. The back takes
// a new request only once the last one has executed and the result register is free.
// While pop is held low the result register keeps its result, the back stops
// after it, and the queue takes up to two more requests before full rises.
// Reset (rst, synchronous) empties the queue and the log and restores the
// register defaults; the entry memory is not cleared, no clearing pass runs,
// and only entries written since then are ever read.
module battery_level_history_log_core import blh_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  cmd_t                  cmd,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output result_t               result
);

  cfg_t  cfg;
  logic  work_valid;
  work_t work;
  logic  work_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.save_level_step         <= SAVE_LEVEL_THRESHOLD_RST;
      cfg.save_period_sec         <= SAVE_INTERVAL_SEC_RST;
      cfg.same_level_interval_sec <= SAME_LEVEL_INTERVAL_SEC_RST;
      cfg.ignore_zero_level       <= 1'b0;
      cfg.skip_on_usb_power       <= 1'b0;
      cfg.force_save_on_sleep     <= 1'b0;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_SAVE_LEVEL_THRESHOLD:    cfg.save_level_step         <= cfg_data[LEVEL_W-1:0];
        REG_SAVE_INTERVAL_SEC:       cfg.save_period_sec         <= cfg_data[TIME_W-1:0];
        REG_SAME_LEVEL_INTERVAL_SEC: cfg.same_level_interval_sec <= cfg_data[TIME_W-1:0];
        REG_IGNORE_ZERO_LEVEL:       cfg.ignore_zero_level       <= cfg_data[0];
        REG_SKIP_ON_USB_POWER:       cfg.skip_on_usb_power       <= cfg_data[0];
        REG_FORCE_SAVE_ON_SLEEP:     cfg.force_save_on_sleep     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify requests into the command queue.
  blh_front u_front (
    .clk               (clk),
    .rst               (rst),
    .ignore_zero_level (cfg.ignore_zero_level),
    .push              (push),
    .cmd               (cmd),
    .full              (full),
    .work_valid        (work_valid),
    .work              (work),
    .work_take         (work_take)
  );

  // Back: entry memory, log state and result register.
  blh_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work_valid (work_valid),
    .work       (work),
    .work_take  (work_take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule

>>> sv/blh_front.sv
module blh_front import blh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  ignore_zero_level,
  input  logic  push,
  input  cmd_t  cmd,
  output logic  full,
  output logic  work_valid,
  output work_t work,
  input  logic  work_take
);

  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  work_t             q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  work_t             classified;
  logic              do_push;

  // Classify the incoming request.
  always_comb begin
    classified.sleep         = (cmd.opcode == OP_SLEEP);
    classified.take          = cmd.level_valid &&
                               !(ignore_zero_level && (cmd.level_percent == '0));
    classified.usb_powered   = cmd.usb_powered;
    classified.timestamp_sec = cmd.timestamp_sec;
    classified.level_percent = cmd.level_percent;
    classified.read_index    = cmd.read_index;
    unique case (cmd.opcode) inside
      OP_SAMPLE, OP_SLEEP: classified.kind = KIND_SAMPLE;
      OP_READ:             classified.kind = KIND_READ;
      default:             classified.kind = KIND_CLEAR;
    endcase
  end

  assign full       = (count == QCNT_W'(QDEPTH));
  assign do_push    = push && !full;
  assign work_valid = (count != '0);
  assign work       = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= classified;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (work_take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !work_take) begin
        count <= count + 1'b1;
      end else if (!do_push && work_take) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/blh_back.sv
`include "battery_level_history_log_core_macros.svh"

module blh_back import blh_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    work_valid,
  input  work_t   work,
  output logic    work_take,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ((CNT_W > RIDX_W) ? CNT_W : RIDX_W) + 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t             state;
  logic               out_valid;
  work_t              cur;
  logic [PTR_W-1:0]   oldest;
  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   unsaved;
  logic [PTR_W-1:0]   first_unsaved;
  logic               first_valid;
  logic [LEVEL_W-1:0] saved_level;
  logic [TIME_W-1:0]  saved_time;
  logic [LEVEL_W-1:0] level_now;
  logic               fresh;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic [PTR_W-1:0]   rd_addr;

  logic [PTR_W-1:0]   oldest_next;
  logic [CNT_W-1:0]   held_next;
  logic [CNT_W-1:0]   unsaved_next;
  logic [PTR_W-1:0]   first_unsaved_next;
  logic               first_valid_next;
  logic [LEVEL_W-1:0] saved_level_next;
  logic [TIME_W-1:0]  saved_time_next;
  logic [LEVEL_W-1:0] level_now_next;
  logic               fresh_next;
  result_t            result_next;

  logic               rec;
  logic               do_save;
  logic [PTR_W-1:0]   slot;
  logic [LEVEL_W-1:0] gap;
  logic [TIME_W-1:0]  dt_newest;
  logic [TIME_W-1:0]  dt_saved;
  logic [TIME_W-1:0]  newest_time;
  logic [LEVEL_W-1:0] newest_level;
  logic               in_range;

  // Wrap a pointer sum by one subtraction of the depth; exact for sums below twice the depth.
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(DEPTH)) ? s - SUM_W'(DEPTH) : s;
    return r[PTR_W-1:0];
  endfunction

  // A request is taken once the result register will be free.
  assign work_take = (state == S_IDLE) && work_valid && (!out_valid || pop);
  assign empty     = !out_valid;

  // Read address: the requested entry for a read, the newest entry otherwise.
  always_comb begin
    if (work.kind == KIND_READ) begin
      rd_addr = wrap_ptr(SUM_W'(oldest) + SUM_W'(work.read_index));
    end else if (held == '0) begin
      rd_addr = oldest;
    end else begin
      rd_addr = wrap_ptr(SUM_W'(oldest) + SUM_W'(held) - SUM_W'(1));
    end
  end

  // Entry memory: one read in the take cycle, one write in the execute cycle.
  always_ff @(posedge clk) begin
    if (state == S_EXEC && rec) begin
      mem[slot] <= {cur.timestamp_sec, cur.level_percent};
    end
    if (work_take) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign newest_time  = rd_data[ENTRY_W-1:LEVEL_W];
  assign newest_level = rd_data[LEVEL_W-1:0];
  assign dt_newest    = cur.timestamp_sec - newest_time;
  assign dt_saved     = cur.timestamp_sec - saved_time;
  assign gap          = (saved_level > cur.level_percent) ?
                        saved_level - cur.level_percent : cur.level_percent - saved_level;
  assign in_range     = SUM_W'(cur.read_index) < SUM_W'(held);

  // Execute the request held in cur against the state and the read data.
  always_comb begin
    oldest_next        = oldest;
    held_next          = held;
    unsaved_next       = unsaved;
    first_unsaved_next = first_unsaved;
    first_valid_next   = first_valid;
    saved_level_next   = saved_level;
    saved_time_next    = saved_time;
    level_now_next     = level_now;
    fresh_next         = fresh;
    rec                = 1'b0;
    do_save            = 1'b0;
    slot               = oldest;
    result_next        = '0;

    case (cur.kind)
      KIND_SAMPLE: begin
        // Decide whether the sample is stored.
        if (cur.take) begin
          level_now_next = cur.level_percent;
          if (cfg.skip_on_usb_power && cur.usb_powered) begin
            rec = 1'b0;
          end else if (fresh) begin
            rec        = 1'b1;
            fresh_next = 1'b0;
          end else if (held == '0) begin
            rec = 1'b1;
          end else if (newest_level != cur.level_percent) begin
            rec = 1'b1;
          end else begin
            rec = (dt_newest >= cfg.same_level_interval_sec);
          end
        end

        // Append, overwriting the oldest entry when the ring is full.
        if (rec) begin
          if (held < CNT_W'(DEPTH)) begin
            slot      = wrap_ptr(SUM_W'(oldest) + SUM_W'(held));
            held_next = held + 1'b1;
          end else begin
            slot        = oldest;
            oldest_next = (oldest == PTR_W'(DEPTH - 1)) ? '0 : oldest + 1'b1;
          end
          if (!first_valid) begin
            first_unsaved_next = slot;
            first_valid_next   = 1'b1;
          end
          if (unsaved < CNT_W'(DEPTH)) begin
            unsaved_next = unsaved + 1'b1;
          end
          do_save = (gap >= cfg.save_level_step) ||
                    (dt_saved >= cfg.save_period_sec);
        end

        // A sleep sample may force out whatever is unsaved.
        if (!do_save && cur.sleep && cfg.force_save_on_sleep && (unsaved_next != '0)) begin
          do_save = 1'b1;
        end

        if (do_save) begin
          result_next.save_now         = 1'b1;
          result_next.save_first_slot  =
            first_valid_next ? SLOT_W'(first_unsaved_next) : '0;
          result_next.save_entry_count = COUNT_W'(unsaved_next);
          unsaved_next       = '0;
          first_valid_next   = 1'b0;
          first_unsaved_next = '0;
          saved_level_next   = level_now_next;
          saved_time_next    = cur.timestamp_sec;
        end

        result_next.recorded    = rec;
        result_next.entry_count = COUNT_W'(held_next);
      end

      KIND_READ: begin
        if (in_range) begin
          result_next.read_time  = newest_time;
          result_next.read_level = newest_level;
          result_next.status     = STATUS_OK;
        end else begin
          result_next.status = STATUS_RANGE;
        end
        result_next.entry_count = COUNT_W'(held);
      end

      default: begin
        // Clear reports how many entries it removed.
        result_next.entry_count = COUNT_W'(held);
        oldest_next        = '0;
        held_next          = '0;
        unsaved_next       = '0;
        first_unsaved_next = '0;
        first_valid_next   = 1'b0;
        fresh_next         = 1'b1;
        saved_level_next   = level_now;
      end
    endcase

    result_next.oldest_slot  = SLOT_W'(oldest_next);
    result_next.level_latest = level_now_next;
  end

  // Sequencer, log state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      oldest        <= '0;
      held          <= '0;
      unsaved       <= '0;
      first_unsaved <= '0;
      first_valid   <= 1'b0;
      saved_level   <= LEVEL_FULL;
      saved_time    <= '0;
      level_now     <= '0;
      fresh         <= 1'b1;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (work_take) begin
            cur   <= work;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          oldest        <= oldest_next;
          held          <= held_next;
          unsaved       <= unsaved_next;
          first_unsaved <= first_unsaved_next;
          first_valid   <= first_valid_next;
          saved_level   <= saved_level_next;
          saved_time    <= saved_time_next;
          level_now     <= level_now_next;
          fresh         <= fresh_next;
          result        <= result_next;
          out_valid     <= 1'b1;
          state         <= S_IDLE;
        end
      endcase
    end
  end

  // Ring bookkeeping stays consistent.
  `BLH_ASSERT_SAME(a_held_range, clk, rst, 1'b1, held <= CNT_W'(DEPTH))
  `BLH_ASSERT_SAME(a_unsaved_le_held, clk, rst, 1'b1, unsaved <= held)
  `BLH_ASSERT_SAME(a_first_valid, clk, rst, 1'b1, first_valid == (unsaved != '0))
  // The result register is free when a request executes, and filled after.
  `BLH_ASSERT_SAME(a_exec_slot_free, clk, rst, state == S_EXEC, !out_valid)
  `BLH_ASSERT_NEXT(a_exec_fills, clk, rst, state == S_EXEC, out_valid)

endmodule

>>> tb/battery_level_history_log_checker.sv
module battery_level_history_log_checker import blh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  input  cmd_t                  cmd,
  input  logic                  full,
  input  logic                  empty,
  input  logic                  pop,
  input  result_t               result,
  output int                    mismatches,
  output int                    waiting,
  output int                    compared,
  output int                    stored_samples,
  output int                    saves_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_DEPTH = DEPTH_DEFAULT;

  // Shadow copy of the log: ring contents, pointers and save bookkeeping.
  logic [ENTRY_W-1:0] ring_model [LOG_DEPTH];
  int unsigned        ring_head;
  int unsigned        ring_held;
  int unsigned        unsaved_cnt;
  int unsigned        unsaved_first;
  bit                 unsaved_first_ok;
  logic [LEVEL_W-1:0] flushed_level;
  logic [TIME_W-1:0]  last_saved_time;
  logic [LEVEL_W-1:0] present_level;
  bit                 log_fresh;
  cfg_t               regs;

  // Results predicted for accepted requests, oldest first.
  result_t            expected_log_results [$];
  int                 error_total = 0;
  int                 checked_total = 0;
  int                 stored_total = 0;
  int                 save_total = 0;

  function automatic void log_mismatch(string msg);
    if (error_total < 10) begin
      $display("[%0t] log result mismatch: %s", $time, msg);
    end
    error_total++;
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] exp,
                                      logic [TIME_W-1:0] got);
    if (got !== exp) begin
      log_mismatch($sformatf("%s expected %0d, got %0d", name, exp, got));
    end
  endfunction

  // A save reports the unsaved span, then starts a new one from this point.
  function automatic void flush_unsaved(inout result_t r, input logic [TIME_W-1:0] ts);
    r.save_now         = 1'b1;
    r.save_first_slot  = unsaved_first_ok ? SLOT_W'(unsaved_first) : '0;
    r.save_entry_count = COUNT_W'(unsaved_cnt);
    unsaved_cnt      = 0;
    unsaved_first    = 0;
    unsaved_first_ok = 1'b0;
    flushed_level    = present_level;
    last_saved_time  = ts;
  endfunction

  // Works out the result of one request and advances the shadow state.
  function automatic result_t log_predict_step(cmd_t c);
    result_t            r;
    logic [ENTRY_W-1:0] newest;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  since_save;
    logic [LEVEL_W-1:0] gap;
    int unsigned        slot;
    bit                 take;
    r = '0;
    case (c.opcode) inside
      OP_SAMPLE, OP_SLEEP: begin
        if (c.level_valid && !(regs.ignore_zero_level && c.level_percent == '0)) begin
          present_level = c.level_percent;
          take = 1'b0;
          // Decide whether the sample goes into the ring.
          if (!(regs.skip_on_usb_power && c.usb_powered)) begin
            if (log_fresh || ring_held == 0) begin
              log_fresh = 1'b0;
              take = 1'b1;
            end else begin
              newest = ring_model[(ring_head + ring_held - 1) % LOG_DEPTH];
              age = c.timestamp_sec - newest[ENTRY_W-1:LEVEL_W];
              take = (newest[LEVEL_W-1:0] != c.level_percent) ||
                     (age >= regs.same_level_interval_sec);
            end
          end
          if (take) begin
            // Append, overwriting the oldest entry once the ring is full.
            if (ring_held < LOG_DEPTH) begin
              slot = (ring_head + ring_held) % LOG_DEPTH;
              ring_held++;
            end else begin
              slot = ring_head;
              ring_head = (ring_head + 1) % LOG_DEPTH;
            end
            ring_model[slot] = {c.timestamp_sec, c.level_percent};
            if (!unsaved_first_ok) begin
              unsaved_first = slot;
              unsaved_first_ok = 1'b1;
            end
            if (unsaved_cnt < LOG_DEPTH) begin
              unsaved_cnt++;
            end
            r.recorded = 1'b1;
            gap = (flushed_level > c.level_percent) ?
                  flushed_level - c.level_percent : c.level_percent - flushed_level;
            since_save = c.timestamp_sec - last_saved_time;
            if (gap >= regs.save_level_step || since_save >= regs.save_period_sec) begin
              flush_unsaved(r, c.timestamp_sec);
            end
          end
        end
        // A sleep sample may flush whatever is still unsaved.
        if (c.opcode == OP_SLEEP && regs.force_save_on_sleep && unsaved_cnt > 0) begin
          flush_unsaved(r, c.timestamp_sec);
        end
        r.entry_count = COUNT_W'(ring_held);
      end
      OP_READ: begin
        if (c.read_index < ring_held) begin
          {r.read_time, r.read_level} = ring_model[(ring_head + c.read_index) % LOG_DEPTH];
          r.status = STATUS_OK;
        end else begin
          r.status = STATUS_RANGE;
        end
        r.entry_count = COUNT_W'(ring_held);
      end
      OP_CLEAR: begin
        // Clear reports how many entries it removed; the save time is kept.
        r.entry_count    = COUNT_W'(ring_held);
        ring_head        = 0;
        ring_held        = 0;
        unsaved_cnt      = 0;
        unsaved_first    = 0;
        unsaved_first_ok = 1'b0;
        log_fresh        = 1'b1;
        flushed_level    = present_level;
      end
    endcase
    r.oldest_slot  = SLOT_W'(ring_head);
    r.level_latest = present_level;
    return r;
  endfunction

  // Watch the three ports; results are matched before new requests are queued.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      ring_head        = 0;
      ring_held        = 0;
      unsaved_cnt      = 0;
      unsaved_first    = 0;
      unsaved_first_ok = 1'b0;
      flushed_level    = LEVEL_FULL;
      last_saved_time  = '0;
      present_level    = '0;
      log_fresh        = 1'b1;
      regs.save_level_step         = SAVE_LEVEL_THRESHOLD_RST;
      regs.save_period_sec         = SAVE_INTERVAL_SEC_RST;
      regs.same_level_interval_sec = SAME_LEVEL_INTERVAL_SEC_RST;
      regs.ignore_zero_level       = 1'b0;
      regs.skip_on_usb_power       = 1'b0;
      regs.force_save_on_sleep     = 1'b0;
      expected_log_results.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_addr)
          REG_SAVE_LEVEL_THRESHOLD:    regs.save_level_step = cfg_data[LEVEL_W-1:0];
          REG_SAVE_INTERVAL_SEC:       regs.save_period_sec = cfg_data[TIME_W-1:0];
          REG_SAME_LEVEL_INTERVAL_SEC: regs.same_level_interval_sec = cfg_data[TIME_W-1:0];
          REG_IGNORE_ZERO_LEVEL:       regs.ignore_zero_level = cfg_data[0];
          REG_SKIP_ON_USB_POWER:       regs.skip_on_usb_power = cfg_data[0];
          REG_FORCE_SAVE_ON_SLEEP:     regs.force_save_on_sleep = cfg_data[0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (expected_log_results.size() == 0) begin
          log_mismatch("result popped while no request was outstanding");
        end else begin
          want = expected_log_results.pop_front();
          check_field("recorded", TIME_W'(want.recorded), TIME_W'(result.recorded));
          check_field("save_now", TIME_W'(want.save_now), TIME_W'(result.save_now));
          check_field("save_first_slot", TIME_W'(want.save_first_slot),
                      TIME_W'(result.save_first_slot));
          check_field("save_entry_count", TIME_W'(want.save_entry_count),
                      TIME_W'(result.save_entry_count));
          check_field("oldest_slot", TIME_W'(want.oldest_slot),
                      TIME_W'(result.oldest_slot));
          check_field("entry_count", TIME_W'(want.entry_count),
                      TIME_W'(result.entry_count));
          check_field("read_time", want.read_time, result.read_time);
          check_field("read_level", TIME_W'(want.read_level), TIME_W'(result.read_level));
          check_field("status", TIME_W'(want.status), TIME_W'(result.status));
          check_field("level_latest", TIME_W'(want.level_latest),
                      TIME_W'(result.level_latest));
          checked_total++;
          stored_total += int'(want.recorded);
          save_total += int'(want.save_now);
        end
      end
      if (push && !full) begin
        expected_log_results.push_back(log_predict_step(cmd));
      end
    end
    mismatches     <= error_total;
    waiting        <= expected_log_results.size();
    compared       <= checked_total;
    stored_samples <= stored_total;
    saves_seen     <= save_total;
  end

endmodule

>>> tb/tb_battery_level_history_log_core.sv
module tb_battery_level_history_log_core;
  timeunit 1ns;
  timeprecision 1ps;
  import blh_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  cmd_t                  cmd = '0;
  logic                  pop = 1'b0;
  logic                  full;
  logic                  empty;
  result_t               result;

  int mismatches;
  int waiting;
  int compared;
  int stored_samples;
  int saves_seen;

  int send_idle_pct = 32;
  int recv_idle_pct = 78;
  int requests_sent = 0;
  int settings_loaded = 0;

  always #6 clk = ~clk;

  battery_level_history_log_core dut (
    .clk, .rst, .cfg_en, .cfg_addr, .cfg_data,
    .push, .cmd, .full, .empty, .pop, .result
  );

  battery_level_history_log_checker log_check (
    .clk, .rst, .cfg_en, .cfg_addr, .cfg_data,
    .push, .cmd, .full, .empty, .pop, .result,
    .mismatches, .waiting, .compared, .stored_samples, .saves_seen
  );

  // The result side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] ts,
                              input logic [LEVEL_W-1:0] lvl, input logic ok,
                              input logic usb, input logic [RIDX_W-1:0] idx);
    cmd_t c;
    c.opcode        = op;
    c.timestamp_sec = ts;
    c.level_percent = lvl;
    c.level_valid   = ok;
    c.usb_powered   = usb;
    c.read_index    = idx;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd  <= c;
    do @(posedge clk); while (full);
    requests_sent++;
  endtask

  // Stops sending and waits until every outstanding request has its result.
  task automatic drain_log();
    push <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_en   <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    @(posedge clk);
  endtask

  task automatic load_registers(input cfg_t s);
    write_reg(REG_SAVE_LEVEL_THRESHOLD, CFG_DATA_W'(s.save_level_step));
    write_reg(REG_SAVE_INTERVAL_SEC, s.save_period_sec);
    write_reg(REG_SAME_LEVEL_INTERVAL_SEC, s.same_level_interval_sec);
    write_reg(REG_IGNORE_ZERO_LEVEL, CFG_DATA_W'(s.ignore_zero_level));
    write_reg(REG_SKIP_ON_USB_POWER, CFG_DATA_W'(s.skip_on_usb_power));
    write_reg(REG_FORCE_SAVE_ON_SLEEP, CFG_DATA_W'(s.force_save_on_sleep));
    cfg_en <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    cfg_t               s;
    logic [TIME_W-1:0]  ts_now;
    logic [LEVEL_W-1:0] lvl;
    logic [OP_W-1:0]    op;
    logic [RIDX_W-1:0]  idx;
    int                 pick;
    int                 lvl_i;
    int                 clear_pct;
    int                 read_pct;
    bit                 tame;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset register values.
    send_request(OP_SAMPLE, 16'd0, 7'd100, 1'b1, 1'b0, 8'd0);      // first after reset
    send_request(OP_SAMPLE, 16'd10, 7'd100, 1'b1, 1'b0, 8'd0);     // same level, too soon
    send_request(OP_SAMPLE, 16'd1300, 7'd100, 1'b1, 1'b0, 8'd0);   // same level, interval up
    send_request(OP_SAMPLE, 16'd1310, 7'd94, 1'b1, 1'b0, 8'd0);    // level move saves
    send_request(OP_SAMPLE, 16'd1320, 7'd50, 1'b0, 1'b0, 8'd0);    // failed reading
    send_request(OP_SLEEP, 16'd1330, 7'd50, 1'b0, 1'b0, 8'd0);     // failed sleep sample
    send_request(OP_SAMPLE, 16'd1340, 7'd0, 1'b1, 1'b1, 8'd0);     // zero level, rules off
    send_request(OP_SAMPLE, 16'hFFFF, 7'd127, 1'b1, 1'b0, 8'hFF);  // level above full
    send_request(OP_SLEEP, 16'd4, 7'd127, 1'b1, 1'b0, 8'd0);       // time wraps
    send_request(OP_READ, 16'd0, 7'd0, 1'b0, 1'b0, 8'd0);
    send_request(OP_READ, 16'hFFFF, 7'd127, 1'b1, 1'b1, 8'd4);
    send_request(OP_READ, 16'd0, 7'd0, 1'b0, 1'b0, 8'd5);          // just past the end
    send_request(OP_READ, 16'd0, 7'd0, 1'b0, 1'b0, 8'hFF);
    send_request(OP_CLEAR, 16'd0, 7'd0, 1'b0, 1'b0, 8'd0);
    send_request(OP_READ, 16'd0, 7'd0, 1'b0, 1'b0, 8'd0);          // read of an empty log
    drain_log();

    // Directed requests with every skip rule and the sleep flush enabled.
    s = '{save_level_step: 7'd100, save_period_sec: 16'hFFFF,
          same_level_interval_sec: 16'd0, ignore_zero_level: 1'b1,
          skip_on_usb_power: 1'b1, force_save_on_sleep: 1'b1};
    load_registers(s);
    send_request(OP_SAMPLE, 16'd100, 7'd0, 1'b1, 1'b0, 8'd0);      // zero level dropped
    send_request(OP_SAMPLE, 16'd150, 7'd40, 1'b1, 1'b1, 8'd0);     // on USB, level only
    send_request(OP_SAMPLE, 16'd200, 7'd50, 1'b1, 1'b0, 8'd0);
    send_request(OP_SAMPLE, 16'd200, 7'd50, 1'b1, 1'b0, 8'd0);
    send_request(OP_SLEEP, 16'd210, 7'd50, 1'b1, 1'b0, 8'd0);      // sleep flushes
    send_request(OP_SLEEP, 16'd220, 7'd50, 1'b0, 1'b0, 8'd0);      // nothing left to flush
    send_request(OP_SLEEP, 16'd230, 7'd0, 1'b1, 1'b0, 8'd0);
    send_request(OP_CLEAR, 16'd240, 7'd0, 1'b0, 1'b0, 8'd0);

    // Random blocks, each under its own register setting, in three idle patterns.
    ts_now = 16'd300;
    lvl = 7'd80;
    for (int blk = 0; blk < 8; blk++) begin
      drain_log();
      case (blk)
        0: s = '{7'd5, 16'd3600, 16'd1200, 1'b0, 1'b0, 1'b1};
        1: s = '{7'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1};
        2: s = '{7'd100, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0};
        3: s = '{7'd127, 16'hFFFF, 16'd0, 1'b1, 1'b0, 1'b0};
        default: begin
          s.save_level_step         = LEVEL_W'($urandom_range(0, 20));
          s.save_period_sec         = TIME_W'($urandom_range(0, 5000));
          s.same_level_interval_sec = TIME_W'($urandom_range(0, 2000));
          s.ignore_zero_level       = 1'($urandom_range(1));
          s.skip_on_usb_power       = 1'($urandom_range(1));
          s.force_save_on_sleep     = 1'($urandom_range(1));
        end
      endcase
      load_registers(s);
      send_idle_pct = (blk < 3) ? 32 : (blk < 6) ? 78 : 0;
      recv_idle_pct = (blk < 3) ? 78 : (blk < 6) ? 32 : 0;
      // Two blocks run without clears and with few reads, so the ring fills,
      // wraps and the unsaved count reaches its ceiling.
      tame      = (blk == 2 || blk == 3);
      clear_pct = tame ? 0 : 2;
      read_pct  = tame ? 10 : 25;
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(99);
        if (pick < clear_pct) begin
          op = OP_CLEAR;
        end else if (pick < clear_pct + read_pct) begin
          op = OP_READ;
        end else if (pick < clear_pct + read_pct + 12) begin
          op = OP_SLEEP;
        end else begin
          op = OP_SAMPLE;
        end
        // Time mostly moves forward by minutes, sometimes jumps anywhere.
        pick = $urandom_range(99);
        if (pick < 70) begin
          ts_now += TIME_W'($urandom_range(0, 400));
        end else if (pick < 90) begin
          ts_now += TIME_W'($urandom_range(400, 4000));
        end else begin
          ts_now = TIME_W'($urandom);
        end
        // The level often repeats or drifts, sometimes hits the edges.
        pick = $urandom_range(99);
        if (pick < 40) begin
          lvl_i = int'(lvl);
        end else if (pick < 75) begin
          lvl_i = int'(lvl) + int'($urandom_range(0, 6)) - 3;
          lvl_i = (lvl_i < 0) ? 0 : (lvl_i > 100) ? 100 : lvl_i;
        end else if (pick < 90) begin
          lvl_i = $urandom_range(0, 100);
        end else if (pick < 95) begin
          lvl_i = 0;
        end else begin
          lvl_i = $urandom_range(101, 127);
        end
        if (tame && (lvl_i < 20 || lvl_i > 90)) begin
          lvl_i = $urandom_range(20, 90);
        end
        lvl = LEVEL_W'(lvl_i);
        idx = ($urandom_range(99) < 80) ? RIDX_W'($urandom_range(0, 135))
                                        : RIDX_W'($urandom_range(0, 255));
        send_request(op, ts_now, lvl, ($urandom_range(99) >= 8),
                     ($urandom_range(99) < 30), idx);
      end
    end
    drain_log();

    $display("Sent %0d requests under %0d register settings; %0d results checked.",
             requests_sent, settings_loaded + 1, compared);
    $display("Samples stored: %0d, saves reported: %0d, results still missing: %0d.",
             stored_samples, saves_seen, waiting);
    if (mismatches == 0 && waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
